### sv/bcld_pkg.sv
`default_nettype none

package bcld_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_ADDR_W      = 2;
    localparam int STATE_W         = 3;
    localparam int EVENT_W         = 3;
    localparam int PRESS_W         = 2;

    localparam logic [STATE_W-1:0] ST_IDLE     = 3'd0;
    localparam logic [STATE_W-1:0] ST_DEBOUNCE = 3'd1;
    localparam logic [STATE_W-1:0] ST_DOWN     = 3'd2;
    localparam logic [STATE_W-1:0] ST_LONG     = 3'd3;
    localparam logic [STATE_W-1:0] ST_WAIT     = 3'd4;

    localparam logic [EVENT_W-1:0] EV_NONE   = 3'd0;
    localparam logic [EVENT_W-1:0] EV_DOWN   = 3'd1;
    localparam logic [EVENT_W-1:0] EV_UP     = 3'd2;
    localparam logic [EVENT_W-1:0] EV_LONG   = 3'd3;
    localparam logic [EVENT_W-1:0] EV_DOUBLE = 3'd4;
    localparam logic [EVENT_W-1:0] EV_CLICK  = 3'd5;

    localparam logic [CFG_ADDR_W-1:0] REG_PRESS_LEVEL = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LONG_PRESS  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DOUBLE_GAP  = 2'd3;

    localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RST   = 16'd4;
    localparam logic [CFG_DATA_W-1:0] LONG_PRESS_RST = 16'd200;
    localparam logic [CFG_DATA_W-1:0] DOUBLE_GAP_RST = 16'd60;

    typedef struct packed {
        logic                  press_level;
        logic [CFG_DATA_W-1:0] debounce_ticks;
        logic [CFG_DATA_W-1:0] long_press_ticks;
        logic [CFG_DATA_W-1:0] double_gap_ticks;
    } cfg_t;

endpackage

`default_nettype wire

### sv/button_click_long_double_detector_core.sv
// Button click / double-click / long-press detector, one instance per button.
// Input channel (s_valid/s_ready/s_pin_level): one transaction per scan tick,
// carrying the raw sampled pin level.
// Result channel (m_valid/m_ready/m_event_code): exactly one transaction per
// input transaction: 0 none, 1 down, 2 up, 3 long press, 4 double click,
// 5 click.
// Configuration: write cfg_wr_en with cfg_addr 0 active level, 1 debounce
// ticks, 2 long-press ticks, 3 double-click gap ticks; write only while idle.
// Latency: the event is presented the cycle after its tick is accepted.
// Throughput: one tick per cycle while the receiver takes each event, set by
// the joint update of the state, tick counter and click counter per tick.
// Reset (aresetn low, synchronous): machine idle, counters zero, registers
// back to level 0 / 4 / 200 / 60 ticks, no pending result.
// Receiver stall: the pending event is held in the output register and
// s_ready drops until it is taken; a tick is accepted in the same cycle the
// pending event leaves.
`default_nettype none

module button_click_long_double_detector_core #(
    parameter int COUNT_WIDTH = bcld_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_pin_level,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [bcld_pkg::EVENT_W-1:0]           m_event_code,
    input  wire logic                              cfg_wr_en,
    input  wire logic [bcld_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [bcld_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    bcld_pkg::cfg_t               cfg;
    logic [bcld_pkg::EVENT_W-1:0] event_next;
    logic [bcld_pkg::STATE_W-1:0] state;
    logic                         load;

    bcld_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bcld_fsm #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_fsm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (load),
        .pin_level  (s_pin_level),
        .cfg        (cfg),
        .event_next (event_next),
        .state      (state)
    );

    bcld_out u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .event_in     (event_next),
        .load         (load),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_event_code (m_event_code)
    );

    a_event_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_event_code <= bcld_pkg::EV_CLICK))
        else $error("event code out of range");

    a_state_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state <= bcld_pkg::ST_WAIT)
        else $error("unused state code reached");

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("accepted tick produced no result");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output register");

endmodule

`default_nettype wire

### sv/bcld_cfg.sv
`default_nettype none

module bcld_cfg (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [bcld_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [bcld_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output bcld_pkg::cfg_t                          cfg
);

    bcld_pkg::cfg_t cfg_reg;
    bcld_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                bcld_pkg::REG_PRESS_LEVEL:  cfg_next.press_level      = cfg_wdata[0];
                bcld_pkg::REG_DEBOUNCE:     cfg_next.debounce_ticks   = cfg_wdata;
                bcld_pkg::REG_LONG_PRESS:   cfg_next.long_press_ticks = cfg_wdata;
                bcld_pkg::REG_DOUBLE_GAP:   cfg_next.double_gap_ticks = cfg_wdata;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.press_level      <= 1'b0;
            cfg_reg.debounce_ticks   <= bcld_pkg::DEBOUNCE_RST;
            cfg_reg.long_press_ticks <= bcld_pkg::LONG_PRESS_RST;
            cfg_reg.double_gap_ticks <= bcld_pkg::DOUBLE_GAP_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### sv/bcld_fsm.sv
`default_nettype none

module bcld_fsm #(
    parameter int COUNT_WIDTH = bcld_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              step_en,
    input  wire logic                              pin_level,
    input  wire bcld_pkg::cfg_t                    cfg,
    output logic [bcld_pkg::EVENT_W-1:0]           event_next,
    output logic [bcld_pkg::STATE_W-1:0]           state
);

    localparam int CMP_W = (COUNT_WIDTH > bcld_pkg::CFG_DATA_W) ?
                           COUNT_WIDTH : bcld_pkg::CFG_DATA_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [bcld_pkg::STATE_W-1:0] state_reg, state_next;
    logic [COUNT_WIDTH-1:0]       tick_reg, tick_next;
    logic [bcld_pkg::PRESS_W-1:0] press_reg, press_next;
    logic                         pressed;
    logic [COUNT_WIDTH-1:0]       tick_bump;
    logic [CMP_W-1:0]             tick_cmp;

    assign pressed   = (pin_level == cfg.press_level);
    assign tick_bump = (tick_reg == CNT_MAX) ? tick_reg : tick_reg + COUNT_WIDTH'(1);
    assign tick_cmp  = CMP_W'(tick_bump);

    always_comb begin
        state_next = state_reg;
        tick_next  = tick_reg;
        press_next = press_reg;
        event_next = bcld_pkg::EV_NONE;
        case (state_reg)
            bcld_pkg::ST_DEBOUNCE: begin
                if (pressed) begin
                    tick_next = tick_bump;
                    if (tick_cmp >= CMP_W'(cfg.debounce_ticks)) begin
                        state_next = bcld_pkg::ST_DOWN;
                        event_next = bcld_pkg::EV_DOWN;
                        tick_next  = '0;
                        if (press_reg == 2'd0) begin
                            press_next = 2'd1;
                        end
                    end
                end else begin
                    state_next = bcld_pkg::ST_IDLE;
                    press_next = '0;
                end
            end
            bcld_pkg::ST_DOWN: begin
                if (pressed) begin
                    tick_next = tick_bump;
                    if (tick_cmp >= CMP_W'(cfg.long_press_ticks)) begin
                        state_next = bcld_pkg::ST_LONG;
                        event_next = bcld_pkg::EV_LONG;
                        tick_next  = '0;
                    end
                end else begin
                    event_next = bcld_pkg::EV_UP;
                    if (press_reg == 2'd1) begin
                        state_next = bcld_pkg::ST_WAIT;
                        tick_next  = '0;
                    end else begin
                        state_next = bcld_pkg::ST_IDLE;
                        press_next = '0;
                    end
                end
            end
            bcld_pkg::ST_LONG: begin
                if (!pressed) begin
                    event_next = bcld_pkg::EV_UP;
                    state_next = bcld_pkg::ST_IDLE;
                    press_next = '0;
                end
            end
            bcld_pkg::ST_WAIT: begin
                if (pressed) begin
                    if (press_reg != 2'd3) begin
                        press_next = press_reg + 2'd1;
                    end
                    event_next = bcld_pkg::EV_DOUBLE;
                    state_next = bcld_pkg::ST_DOWN;
                    tick_next  = '0;
                end else begin
                    tick_next = tick_bump;
                    if (tick_cmp >= CMP_W'(cfg.double_gap_ticks)) begin
                        if (press_reg == 2'd1) begin
                            event_next = bcld_pkg::EV_CLICK;
                        end
                        state_next = bcld_pkg::ST_IDLE;
                        press_next = '0;
                    end
                end
            end
            default: begin
                state_next = bcld_pkg::ST_IDLE;
                if (pressed) begin
                    tick_next  = '0;
                    state_next = bcld_pkg::ST_DEBOUNCE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bcld_pkg::ST_IDLE;
            tick_reg  <= '0;
            press_reg <= '0;
        end else if (step_en) begin
            state_reg <= state_next;
            tick_reg  <= tick_next;
            press_reg <= press_next;
        end
    end

    assign state = state_reg;

endmodule

`default_nettype wire

### sv/bcld_out.sv
`default_nettype none

module bcld_out (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [bcld_pkg::EVENT_W-1:0]      event_in,
    output logic                                   load,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [bcld_pkg::EVENT_W-1:0]           m_event_code
);

    logic                         m_valid_reg, m_valid_next;
    logic [bcld_pkg::EVENT_W-1:0] event_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign load    = s_valid && s_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // hold the event while the receiver stalls
    always_ff @(posedge aclk) begin
        if (load) begin
            event_reg <= event_in;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_event_code = event_reg;

endmodule

`default_nettype wire
